// ----- rtl/dlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared types, codes and mode tables for the dual LED status pattern driver.
// ----------------------------------------------------------------------------
package dlsp_pkg;

    // Default counter width of each LED tick counter
    localparam int COUNT_BITS_DEFAULT = 16;

    // Width of the configuration thresholds
    localparam int CFG_W = 16;

    // Status field width and notable status codes
    localparam int STATUS_W = 4;
    localparam logic [STATUS_W-1:0] STATUS_LAST_NORMAL    = 4'd6;
    localparam logic [STATUS_W-1:0] STATUS_CRIT_BOTH_SLOW = 4'd7;
    localparam logic [STATUS_W-1:0] STATUS_CRIT_BOTH_FAST = 4'd10;
    localparam logic [STATUS_W-1:0] STATUS_LAST_KNOWN     = 4'd10;

    // Register file: indexes and bus widths
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_OFF_TICKS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLOW_HALF_PERIOD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FAST_HALF_PERIOD = 2'd2;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] DIM_OFF_TICKS_RST    = 16'd10;
    localparam logic [CFG_W-1:0] SLOW_HALF_PERIOD_RST = 16'd500;
    localparam logic [CFG_W-1:0] FAST_HALF_PERIOD_RST = 16'd100;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // LED display mode
    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_DIM    = 3'd1,
        MODE_BRIGHT = 3'd2,
        MODE_SLOW   = 3'd3,
        MODE_FAST   = 3'd4
    } led_mode_t;

    // Configuration thresholds
    typedef struct packed {
        logic [CFG_W-1:0] dim_off_ticks;
        logic [CFG_W-1:0] slow_half_period;
        logic [CFG_W-1:0] fast_half_period;
    } cfg_t;

    // One tick beat
    typedef struct packed {
        logic                config_valid;
        logic                magnet_present;
        logic [STATUS_W-1:0] switch_status;
    } tick_t;

    // Alternate phasing request from the mode selector to an LED
    typedef struct packed {
        logic             load;
        logic             lit;
        logic [CFG_W-1:0] half;
    } phase_t;

    // LED1 mode for a known status code
    function automatic led_mode_t led1_mode(input logic [STATUS_W-1:0] status);
        led_mode_t m;
        case (status)
            4'd0:    m = MODE_DIM;
            4'd1:    m = MODE_DIM;
            4'd2:    m = MODE_SLOW;
            4'd3:    m = MODE_DIM;
            4'd4:    m = MODE_FAST;
            4'd5:    m = MODE_FAST;
            4'd6:    m = MODE_OFF;
            4'd7:    m = MODE_SLOW;
            4'd8:    m = MODE_SLOW;
            4'd9:    m = MODE_FAST;
            4'd10:   m = MODE_FAST;
            default: m = MODE_OFF;
        endcase
        return m;
    endfunction

    // LED2 mode for a known status code
    function automatic led_mode_t led2_mode(input logic [STATUS_W-1:0] status);
        led_mode_t m;
        case (status)
            4'd0:    m = MODE_OFF;
            4'd1:    m = MODE_SLOW;
            4'd2:    m = MODE_DIM;
            4'd3:    m = MODE_FAST;
            4'd4:    m = MODE_DIM;
            4'd5:    m = MODE_OFF;
            4'd6:    m = MODE_FAST;
            4'd7:    m = MODE_SLOW;
            4'd8:    m = MODE_FAST;
            4'd9:    m = MODE_SLOW;
            4'd10:   m = MODE_FAST;
            default: m = MODE_OFF;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/dlsp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dlsp_cfg_regs
// APB register file holding the dim and blink thresholds.
// ----------------------------------------------------------------------------
module dlsp_cfg_regs
    import dlsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dim_off_ticks    <= DIM_OFF_TICKS_RST;
            cfg_reg.slow_half_period <= SLOW_HALF_PERIOD_RST;
            cfg_reg.fast_half_period <= FAST_HALF_PERIOD_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DIM_OFF_TICKS:    cfg_reg.dim_off_ticks    <= pwdata[CFG_W-1:0];
                REG_SLOW_HALF_PERIOD: cfg_reg.slow_half_period <= pwdata[CFG_W-1:0];
                REG_FAST_HALF_PERIOD: cfg_reg.fast_half_period <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_DIM_OFF_TICKS:
                prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.dim_off_ticks};
            REG_SLOW_HALF_PERIOD:
                prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.slow_half_period};
            REG_FAST_HALF_PERIOD:
                prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.fast_half_period};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/dlsp_mode_sel.sv -----
// ----------------------------------------------------------------------------
// dlsp_mode_sel
// Holds both LED modes and the critical flag; decodes the switch status.
// ----------------------------------------------------------------------------
module dlsp_mode_sel
    import dlsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,        // a tick is processed this cycle
    input  tick_t     tick,
    input  cfg_t      cfg,
    output led_mode_t mode1,     // mode in effect for this tick
    output led_mode_t mode2,
    output phase_t    phase1,
    output phase_t    phase2
);

    led_mode_t mode1_reg, mode1_next;
    led_mode_t mode2_reg, mode2_next;
    logic      crit_reg,  crit_next;
    logic      known;
    logic      critical;

    assign known    = tick.switch_status <= STATUS_LAST_KNOWN;
    assign critical = tick.switch_status > STATUS_LAST_NORMAL;

    // Next modes, critical flag and phasing request
    always_comb begin
        mode1_next = mode1_reg;
        mode2_next = mode2_reg;
        crit_next  = crit_reg;
        phase1     = '{load: 1'b0, lit: 1'b1, half: cfg.slow_half_period};
        phase2     = '{load: 1'b0, lit: 1'b0, half: cfg.slow_half_period};
        if (known) begin
            mode1_next = led1_mode(tick.switch_status);
            mode2_next = led2_mode(tick.switch_status);
            crit_next  = critical;
            // Entering a dual-blink critical case: LEDs alternate
            if (!crit_reg) begin
                if (tick.switch_status == STATUS_CRIT_BOTH_SLOW) begin
                    phase1.load = 1'b1;
                    phase2.load = 1'b1;
                end else if (tick.switch_status == STATUS_CRIT_BOTH_FAST) begin
                    phase1.load = 1'b1;
                    phase2.load = 1'b1;
                    phase1.half = cfg.fast_half_period;
                    phase2.half = cfg.fast_half_period;
                end
            end
        end
        if (tick.magnet_present) begin
            mode2_next = MODE_BRIGHT;
        end
    end

    assign mode1 = mode1_next;
    assign mode2 = mode2_next;

    // State update on valid-config ticks only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode1_reg <= MODE_OFF;
            mode2_reg <= MODE_OFF;
            crit_reg  <= 1'b0;
        end else if (en && tick.config_valid) begin
            mode1_reg <= mode1_next;
            mode2_reg <= mode2_next;
            crit_reg  <= crit_next;
        end
    end

endmodule

// ----- rtl/dlsp_led_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlsp_led_ctrl
// One LED: lit state and tick counter, stepped by the selected mode.
// ----------------------------------------------------------------------------
module dlsp_led_ctrl
    import dlsp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      config_valid,
    input  led_mode_t mode,
    input  phase_t    phase,
    input  cfg_t      cfg,
    output logic      lit_next
);

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic                  lit_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] cnt_base, cnt_mid;
    logic                  lit_base, lit_mid;
    logic [CFG_W:0]        half_p1;
    logic [CMP_W-1:0]      cnt_cmp;
    logic                  over_dim, over_slow, over_fast;

    // Starting point: current state or alternate phasing load
    assign half_p1  = {1'b0, phase.half} + {{CFG_W{1'b0}}, 1'b1};
    assign cnt_base = phase.load ? COUNT_BITS'(half_p1) : cnt_reg;
    assign lit_base = phase.load ? phase.lit : lit_reg;

    assign cnt_cmp   = CMP_W'(cnt_base);
    assign over_dim  = cnt_cmp > CMP_W'(cfg.dim_off_ticks);
    assign over_slow = cnt_cmp > CMP_W'(cfg.slow_half_period);
    assign over_fast = cnt_cmp > CMP_W'(cfg.fast_half_period);

    // Mode step
    always_comb begin
        lit_mid = lit_base;
        cnt_mid = cnt_base;
        case (mode)
            MODE_OFF: begin
                lit_mid = 1'b0;
                cnt_mid = '0;
            end
            MODE_DIM: begin
                if (!lit_base && over_dim) begin
                    lit_mid = 1'b1;
                    cnt_mid = '0;
                end else begin
                    lit_mid = 1'b0;
                end
            end
            MODE_BRIGHT: begin
                lit_mid = 1'b1;
                cnt_mid = '0;
            end
            MODE_SLOW: begin
                if (over_slow) begin
                    lit_mid = ~lit_base;
                    cnt_mid = '0;
                end
            end
            MODE_FAST: begin
                if (over_fast) begin
                    lit_mid = ~lit_base;
                    cnt_mid = '0;
                end
            end
            default: ;
        endcase
        cnt_next = cnt_mid + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        // Config error pattern: lit, counter held
        lit_next = config_valid ? lit_mid : 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (en) begin
            lit_reg <= lit_next;
            if (config_valid) begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ----- rtl/dual_led_status_pattern_driver.sv -----
// ----------------------------------------------------------------------------
// dual_led_status_pattern_driver
// Turns millisecond status ticks into the lit levels of two status LEDs.
// ----------------------------------------------------------------------------
// Each input beat is one tick and produces exactly one output beat holding
// the lit levels of LED1 and LED2 after that tick. A beat is registered on
// input, then the mode decode and both LED counter steps run combinationally
// into the output register. A new beat is taken every cycle while the output
// side keeps up. The user must write the thresholds over the APB port only
// while no tick is in flight; the block itself does not enforce this.
module dual_led_status_pattern_driver
    import dlsp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] switch_status, [4] magnet_present,
                                             // [5] config_valid, [7:6] zero
    // LED result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] led1_on, [1] led2_on, [7:2] zero
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    tick_t     tick_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic [1:0] leds_reg;
    logic      step;
    led_mode_t mode1, mode2;
    phase_t    phase1, phase2;
    logic      led1_next, led2_next;

    // Handshake: a tick steps when the output register is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    dlsp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= tick_t'(s_tdata[5:0]);
        end
    end

    dlsp_mode_sel u_mode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step),
        .tick    (tick_reg),
        .cfg     (cfg),
        .mode1   (mode1),
        .mode2   (mode2),
        .phase1  (phase1),
        .phase2  (phase2)
    );

    dlsp_led_ctrl #(.COUNT_BITS(COUNT_BITS)) u_led1 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (step),
        .config_valid (tick_reg.config_valid),
        .mode         (mode1),
        .phase        (phase1),
        .cfg          (cfg),
        .lit_next     (led1_next)
    );

    dlsp_led_ctrl #(.COUNT_BITS(COUNT_BITS)) u_led2 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (step),
        .config_valid (tick_reg.config_valid),
        .mode         (mode2),
        .phase        (phase2),
        .cfg          (cfg),
        .lit_next     (led2_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            leds_reg <= {led2_next, led1_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, leds_reg};

endmodule
